@@ rtl/core/swm_pkg.sv @@
// Shared types and constants of the sliding window median filter.
package swm_pkg;

  localparam int SampleW   = 64;
  localparam int CountW    = 6;
  localparam int GroupW    = 8;
  localparam int WindowMax = 32;

  typedef struct packed {
    logic [SampleW-1:0] val;
    logic               vld;
    logic               le;
  } swm_link_t;

  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic [SampleW-1:0] old;
    logic               shift;
    logic               full;
    logic               clr;
  } swm_ctl_t;

endpackage

@@ rtl/core/swm_cell.sv @@
// One sorted cell: removes the oldest sample and inserts the new one in rank order.
module swm_cell import swm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  swm_ctl_t  ctl_i,
  input  swm_link_t left_rem_i,
  input  swm_link_t right_raw_i,
  output swm_link_t raw_o,
  output swm_link_t rem_o
);

  logic [SampleW-1:0] val_q, val_d;
  logic               vld_q, vld_d;
  logic               le, ge;

  always_comb begin
    le = vld_q && ($signed(val_q) <= $signed(ctl_i.smp));
    ge = ctl_i.full && (!vld_q || ($signed(val_q) >= $signed(ctl_i.old)));
    raw_o.val = val_q;
    raw_o.vld = vld_q;
    raw_o.le  = le;
    rem_o     = ge ? right_raw_i : raw_o;
    val_d     = val_q;
    vld_d     = vld_q;
    if (ctl_i.clr) begin
      vld_d = 1'b0;
    end else if (ctl_i.shift) begin
      if (rem_o.le) begin
        val_d = rem_o.val;
        vld_d = rem_o.vld;
      end else if (left_rem_i.le) begin
        val_d = ctl_i.smp;
        vld_d = 1'b1;
      end else begin
        val_d = left_rem_i.val;
        vld_d = left_rem_i.vld;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ rtl/core/swm_select.sv @@
// Median pick from the sorted cells, middle pair mean and output register.
module swm_select import swm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  output logic               in_rdy_o,
  input  logic [SampleW-1:0] vals_i [WindowMax],
  input  logic [CountW-1:0]  fill_i,
  output logic               out_vld_o,
  input  logic               out_rdy_i,
  output logic [SampleW-1:0] med_o,
  output logic [CountW-1:0]  held_o
);

  localparam int NumGrp = (WindowMax + GroupW - 1) / GroupW;

  logic [SampleW-1:0] lo_grp_d [NumGrp];
  logic [SampleW-1:0] hi_grp_d [NumGrp];
  logic [SampleW-1:0] p1_lo_q [NumGrp];
  logic [SampleW-1:0] p1_hi_q [NumGrp];
  logic               p1_vld_q;
  logic               p1_odd_q;
  logic [CountW-1:0]  p1_fill_q;
  logic [SampleW-1:0] lo_all, hi_all;
  logic [SampleW:0]   sum_d;
  logic               p2_vld_q;
  logic               p2_odd_q;
  logic [SampleW-1:0] p2_hi_q;
  logic [SampleW:0]   p2_sum_q;
  logic [CountW-1:0]  p2_fill_q;
  logic [SampleW:0]   rnd;
  logic               out_vld_q;
  logic [SampleW-1:0] out_med_q;
  logic [CountW-1:0]  out_fill_q;
  logic               out_free, p2_free, p1_free;
  logic               p1_load, p2_load, out_load;

  assign out_free = !out_vld_q || out_rdy_i;
  assign p2_free  = !p2_vld_q || out_free;
  assign p1_free  = !p1_vld_q || p2_free;
  assign out_load = p2_vld_q && out_free;
  assign p2_load  = p1_vld_q && p2_free;
  assign p1_load  = in_vld_i && p1_free;
  assign in_rdy_o = !in_vld_i || p1_free;

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      lo_grp_d[g] = '0;
      hi_grp_d[g] = '0;
      for (int k = 0; k < GroupW; k++) begin
        if (g * GroupW + k < WindowMax) begin
          if (int'(fill_i[CountW-1:1]) == g * GroupW + k) begin
            hi_grp_d[g] = hi_grp_d[g] | vals_i[g * GroupW + k];
          end
          if (int'(fill_i[CountW-1:1]) == g * GroupW + k + 1) begin
            lo_grp_d[g] = lo_grp_d[g] | vals_i[g * GroupW + k];
          end
        end
      end
    end
  end

  always_comb begin
    lo_all = '0;
    hi_all = '0;
    for (int g = 0; g < NumGrp; g++) begin
      lo_all = lo_all | p1_lo_q[g];
      hi_all = hi_all | p1_hi_q[g];
    end
    sum_d = {lo_all[SampleW-1], lo_all} + {hi_all[SampleW-1], hi_all};
    rnd   = p2_sum_q + {{SampleW{1'b0}}, p2_sum_q[SampleW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_vld_q <= in_vld_i;
      end
      if (p2_free) begin
        p2_vld_q <= p1_vld_q;
      end
      if (out_free) begin
        out_vld_q <= p2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_load) begin
      p1_lo_q   <= lo_grp_d;
      p1_hi_q   <= hi_grp_d;
      p1_odd_q  <= fill_i[0];
      p1_fill_q <= fill_i;
    end
    if (p2_load) begin
      p2_hi_q   <= hi_all;
      p2_sum_q  <= sum_d;
      p2_odd_q  <= p1_odd_q;
      p2_fill_q <= p1_fill_q;
    end
    if (out_load) begin
      out_med_q  <= p2_odd_q ? p2_hi_q : rnd[SampleW:1];
      out_fill_q <= p2_fill_q;
    end
  end

  assign out_vld_o = out_vld_q;
  assign med_o     = out_med_q;
  assign held_o    = out_fill_q;

endmodule

@@ rtl/core/sliding_window_median.sv @@
// Top level of the sliding window median filter over signed 64-bit samples.
//
// Channel   Direction  Contents
// s_axis    in         tdata[63:0] sample
// m_axis    out        tdata[63:0] median, tdata[69:64] samples_held, tdata[71:70] zero
// cfg_wr    in         cfg_wr_data_i[5:0] window_size
//
// One sample is taken per clock while the result path is not stalled.
// A result passes through the sorted cell row update, the median pick, the
// middle pair mean and the output register, in that order.
// Reset and a window_size write empty the window and restart the ring.
// A stalled output backs up the pick pipeline and then drops s_axis_tready.
module sliding_window_median import swm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // [63:0] sample
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata,   // [63:0] median, [69:64] samples_held
  input  logic               cfg_wr_en_i,
  input  logic [CountW-1:0]  cfg_wr_data_i
);

  localparam int SlotW = (WindowMax > 1) ? $clog2(WindowMax) : 1;

  logic [CountW-1:0]  win_q, win_d;
  logic [CountW-1:0]  fill_q, fill_d;
  logic [SlotW-1:0]   slot_q, slot_d, slot_nxt;
  logic               pend_q, pend_d;
  logic [SampleW-1:0] old_q;
  logic [SampleW-1:0] ring [WindowMax];
  logic               accept, full, sel_rdy;
  swm_ctl_t           ctl;
  swm_link_t          raw_l [WindowMax+1];
  swm_link_t          rem_l [WindowMax+1];
  logic [SampleW-1:0] vals [WindowMax];
  logic [SampleW-1:0] med;
  logic [CountW-1:0]  held;

  assign s_axis_tready = sel_rdy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (fill_q == win_q);
  assign slot_nxt      = (int'(slot_q) + 1 == int'(win_q)) ? '0 : slot_q + SlotW'(1);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    slot_d = slot_q;
    pend_d = pend_q;
    if (pend_q && sel_rdy) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
      slot_d = slot_nxt;
      if (!full) begin
        fill_d = fill_q + CountW'(1);
      end
    end
    if (cfg_wr_en_i) begin
      fill_d = '0;
      slot_d = '0;
      if (cfg_wr_data_i == '0) begin
        win_d = CountW'(1);
      end else if (int'(cfg_wr_data_i) > WindowMax) begin
        win_d = CountW'(WindowMax);
      end else begin
        win_d = cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= CountW'(1);
      fill_q <= '0;
      slot_q <= '0;
      pend_q <= 1'b0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
      slot_q <= slot_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring[slot_q] <= s_axis_tdata;
      if (slot_nxt == slot_q) begin
        old_q <= s_axis_tdata;
      end else begin
        old_q <= ring[slot_nxt];
      end
    end
  end

  assign ctl.smp   = s_axis_tdata;
  assign ctl.old   = old_q;
  assign ctl.shift = accept;
  assign ctl.full  = full;
  assign ctl.clr   = cfg_wr_en_i;

  assign rem_l[0].val         = '0;
  assign rem_l[0].vld         = 1'b1;
  assign rem_l[0].le          = 1'b1;
  assign raw_l[WindowMax].val = '0;
  assign raw_l[WindowMax].vld = 1'b0;
  assign raw_l[WindowMax].le  = 1'b0;

  for (genvar i = 0; i < WindowMax; i++) begin : g_cell
    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_rem_i  (rem_l[i]),
      .right_raw_i (raw_l[i+1]),
      .raw_o       (raw_l[i]),
      .rem_o       (rem_l[i+1])
    );
    assign vals[i] = raw_l[i].val;
  end

  swm_select u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (pend_q),
    .in_rdy_o  (sel_rdy),
    .vals_i    (vals),
    .fill_i    (fill_q),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .med_o     (med),
    .held_o    (held)
  );

  assign m_axis_tdata = {2'b00, held, med};

endmodule
